@@ design/sust_pkg.sv @@
`timescale 1ns / 1ps
// Package for the sorted unique set table: item structs, operation and
// status codes, sequencer states. No dependencies.
package sust_pkg;

    localparam int CAPACITY_DEF = 16;
    localparam int VALUE_W      = 32;

    typedef enum logic [1:0] {
        MODE_INSERT = 2'd0,
        MODE_REMOVE = 2'd1,
        MODE_DUMP   = 2'd2
    } mode_t;

    typedef enum logic [2:0] {
        STAT_INSERTED  = 3'd0,
        STAT_DUPLICATE = 3'd1,
        STAT_FULL      = 3'd2,
        STAT_REMOVED   = 3'd3,
        STAT_NOTFOUND  = 3'd4,
        STAT_EMPTY     = 3'd5,
        STAT_LISTED    = 3'd6
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_TAIL,
        S_RESP
    } state_t;

    typedef struct packed {
        mode_t                     mode;
        logic signed [VALUE_W-1:0] value;
    } req_t;

    typedef struct packed {
        status_t                   status;
        logic signed [VALUE_W-1:0] value_out;
        logic                      last;
    } rsp_t;

endpackage

@@ design/sorted_unique_set_table.sv @@
`timescale 1ns / 1ps
// Sorted unique set table: top level with the entry memory and its sequencer.
// Depends on sust_pkg.

// Holds up to CAPACITY distinct signed 32-bit values in ascending order in a
// synchronous single-read, single-write memory. Each insert, remove and dump
// on a non-empty table makes at most one ascending pass over the stored
// entries, one entry per clock while a dump is not stalled by a full result
// register, as the memory delivers one read per cycle. Insert shifts larger
// entries up on the fly and stops early on a duplicate or a full table;
// remove shifts later entries down and stops early at a larger entry if the
// value is absent. A remove or dump on an empty table goes straight to its
// result. A result waiting in a full result register holds up the next item.
// One item is worked on at a time; the result register lets the next item
// in while the last result waits to be taken. The memory needs no clearing
// after reset: only the first entry_count entries are ever read.
module sorted_unique_set_table
    import sust_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_ready,
    input  req_t req,
    output logic rsp_valid,
    input  logic rsp_ready,
    output rsp_t rsp
);

    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W = $clog2(CAPACITY + 1);

    // entry memory
    logic signed [VALUE_W-1:0] mem [CAPACITY];
    logic signed [VALUE_W-1:0] mem_q;
    logic                      rd_en;
    logic [IDX_W-1:0]          rd_addr;
    logic                      wr_en;
    logic [IDX_W-1:0]          wr_addr;
    logic signed [VALUE_W-1:0] wr_data;

    state_t                    state_reg, state_next;
    mode_t                     op_reg, op_next;
    logic signed [VALUE_W-1:0] val_reg, val_next;
    logic [IDX_W-1:0]          idx_reg, idx_next;
    logic [CNT_W-1:0]          cnt_reg, cnt_next;
    logic                      flag_reg, flag_next;   // placed (insert) / found (remove)
    logic signed [VALUE_W-1:0] carry_reg, carry_next;
    status_t                   res_status_reg, res_status_next;
    logic signed [VALUE_W-1:0] res_value_reg, res_value_next;
    logic                      out_valid_reg, out_valid_next;
    rsp_t                      out_reg, out_next;

    logic out_free;
    logic full;
    logic last_i;
    logic hit;
    logic above;
    logic found_now;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            mem_q <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        val_reg        <= val_next;
        idx_reg        <= idx_next;
        flag_reg       <= flag_next;
        carry_reg      <= carry_next;
        res_status_reg <= res_status_next;
        res_value_reg  <= res_value_next;
        out_reg        <= out_next;
    end

    assign req_ready = (state_reg == S_IDLE);
    assign rsp_valid = out_valid_reg;
    assign rsp       = out_reg;

    assign out_free  = !out_valid_reg || rsp_ready;
    assign full      = (cnt_reg == CNT_W'(CAPACITY));
    assign last_i    = ((CNT_W'(idx_reg) + CNT_W'(1)) == cnt_reg);
    assign hit       = (mem_q == val_reg);
    assign above     = (mem_q > val_reg);
    assign found_now = flag_reg || hit;

    always_comb
    begin
        state_next      = state_reg;
        op_next         = op_reg;
        val_next        = val_reg;
        idx_next        = idx_reg;
        cnt_next        = cnt_reg;
        flag_next       = flag_reg;
        carry_next      = carry_reg;
        res_status_next = res_status_reg;
        res_value_next  = res_value_reg;
        out_valid_next  = out_valid_reg && !rsp_ready;
        out_next        = out_reg;
        rd_en           = 1'b0;
        rd_addr         = idx_reg + IDX_W'(1);
        wr_en           = 1'b0;
        wr_addr         = idx_reg;
        wr_data         = val_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    op_next   = req.mode;
                    val_next  = req.value;
                    flag_next = 1'b0;
                    idx_next  = '0;
                    case (req.mode) inside
                        MODE_INSERT:
                        begin
                            if (cnt_reg == '0)
                            begin
                                state_next = S_TAIL;
                            end
                            else
                            begin
                                rd_en      = 1'b1;
                                rd_addr    = '0;
                                state_next = S_SCAN;
                            end
                        end
                        MODE_REMOVE, MODE_DUMP:
                        begin
                            if (cnt_reg == '0)
                            begin
                                res_status_next = STAT_EMPTY;
                                res_value_next  = '0;
                                state_next      = S_RESP;
                            end
                            else
                            begin
                                rd_en      = 1'b1;
                                rd_addr    = '0;
                                state_next = S_SCAN;
                            end
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end

            S_SCAN:
            begin
                // mem_q holds entry idx_reg
                case (op_reg)
                    MODE_INSERT:
                    begin
                        if (!flag_reg && hit)
                        begin
                            res_status_next = STAT_DUPLICATE;
                            res_value_next  = '0;
                            state_next      = S_RESP;
                        end
                        else if (!flag_reg && above && full)
                        begin
                            res_status_next = STAT_FULL;
                            res_value_next  = '0;
                            state_next      = S_RESP;
                        end
                        else
                        begin
                            // once placed, each entry moves up one slot
                            if (flag_reg)
                            begin
                                wr_en      = 1'b1;
                                wr_data    = carry_reg;
                                carry_next = mem_q;
                            end
                            else if (above)
                            begin
                                wr_en      = 1'b1;
                                wr_data    = val_reg;
                                carry_next = mem_q;
                                flag_next  = 1'b1;
                            end
                            if (last_i)
                            begin
                                state_next = S_TAIL;
                            end
                            else
                            begin
                                rd_en    = 1'b1;
                                idx_next = idx_reg + IDX_W'(1);
                            end
                        end
                    end
                    MODE_REMOVE:
                    begin
                        if (!flag_reg && above)
                        begin
                            res_status_next = STAT_NOTFOUND;
                            res_value_next  = '0;
                            state_next      = S_RESP;
                        end
                        else
                        begin
                            // entries past the match move down one slot
                            if (flag_reg)
                            begin
                                wr_en   = 1'b1;
                                wr_addr = idx_reg - IDX_W'(1);
                                wr_data = mem_q;
                            end
                            flag_next = found_now;
                            if (last_i)
                            begin
                                if (found_now)
                                begin
                                    cnt_next        = cnt_reg - CNT_W'(1);
                                    res_status_next = STAT_REMOVED;
                                    res_value_next  = val_reg;
                                end
                                else
                                begin
                                    res_status_next = STAT_NOTFOUND;
                                    res_value_next  = '0;
                                end
                                state_next = S_RESP;
                            end
                            else
                            begin
                                rd_en    = 1'b1;
                                idx_next = idx_reg + IDX_W'(1);
                            end
                        end
                    end
                    MODE_DUMP:
                    begin
                        // stall with the read data held until the result slot frees
                        if (out_free)
                        begin
                            out_valid_next    = 1'b1;
                            out_next.status    = STAT_LISTED;
                            out_next.value_out = mem_q;
                            out_next.last      = last_i;
                            if (last_i)
                            begin
                                state_next = S_IDLE;
                            end
                            else
                            begin
                                rd_en    = 1'b1;
                                idx_next = idx_reg + IDX_W'(1);
                            end
                        end
                    end
                    default:
                    begin
                        state_next = S_IDLE;
                    end
                endcase
            end

            S_TAIL:
            begin
                if (!flag_reg && full)
                begin
                    res_status_next = STAT_FULL;
                    res_value_next  = '0;
                end
                else
                begin
                    wr_en           = 1'b1;
                    wr_addr         = cnt_reg[IDX_W-1:0];
                    wr_data         = flag_reg ? carry_reg : val_reg;
                    cnt_next        = cnt_reg + CNT_W'(1);
                    res_status_next = STAT_INSERTED;
                    res_value_next  = val_reg;
                end
                state_next = S_RESP;
            end

            S_RESP:
            begin
                if (out_free)
                begin
                    out_valid_next     = 1'b1;
                    out_next.status    = res_status_reg;
                    out_next.value_out = res_value_reg;
                    out_next.last      = 1'b1;
                    state_next         = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(CAPACITY))
        else $error("entry count above capacity");

    a_scan_idx: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_SCAN |-> CNT_W'(idx_reg) < cnt_reg)
        else $error("scan index past stored entries");

    a_wr_state: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> (state_reg == S_SCAN || state_reg == S_TAIL))
        else $error("memory write outside scan or tail");

    a_cnt_change: assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(cnt_reg) |-> ($past(state_reg) == S_SCAN || $past(state_reg) == S_TAIL))
        else $error("entry count changed outside an update pass");

endmodule

@@ tb/sv/sust_set_checker.sv @@
`timescale 1ns / 1ps
// Checker for the sorted unique set table: watches both channels, keeps its
// own copy of the stored set and compares each result. Depends on sust_pkg.
module sust_set_checker
    import sust_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    input  logic req_ready,
    input  req_t req,
    input  logic rsp_valid,
    input  logic rsp_ready,
    input  rsp_t rsp,
    output int   mismatches,
    output int   outstanding,
    output int   results_seen,
    output int   full_replies,
    output int   dup_replies,
    output int   peak_fill
);

    // ascending, no duplicates
    logic signed [VALUE_W-1:0] set_vals[$];
    rsp_t                      expected_rsps[$];

    function automatic rsp_t make_rsp(input status_t s, input logic signed [VALUE_W-1:0] v,
                                      input logic l);
        rsp_t r;
        r.status    = s;
        r.value_out = v;
        r.last      = l;
        return r;
    endfunction

    // first position whose stored value is not below v
    function automatic int lower_slot(input logic signed [VALUE_W-1:0] v);
        int pos;
        pos = 0;
        while (pos < set_vals.size() && set_vals[pos] < v)
            pos++;
        return pos;
    endfunction

    task automatic predict_item(input req_t r);
        logic signed [VALUE_W-1:0] v;
        int                        pos;
        v = r.value;
        case (r.mode)
            MODE_INSERT:
            begin
                pos = lower_slot(v);
                if (pos < set_vals.size() && set_vals[pos] == v)
                    expected_rsps.push_back(make_rsp(STAT_DUPLICATE, '0, 1'b1));
                else if (set_vals.size() >= CAPACITY)
                    expected_rsps.push_back(make_rsp(STAT_FULL, '0, 1'b1));
                else
                begin
                    set_vals.insert(pos, v);
                    expected_rsps.push_back(make_rsp(STAT_INSERTED, v, 1'b1));
                end
            end
            MODE_REMOVE:
            begin
                pos = lower_slot(v);
                if (set_vals.size() == 0)
                    expected_rsps.push_back(make_rsp(STAT_EMPTY, '0, 1'b1));
                else if (pos >= set_vals.size() || set_vals[pos] != v)
                    expected_rsps.push_back(make_rsp(STAT_NOTFOUND, '0, 1'b1));
                else
                begin
                    set_vals.delete(pos);
                    expected_rsps.push_back(make_rsp(STAT_REMOVED, v, 1'b1));
                end
            end
            MODE_DUMP:
            begin
                if (set_vals.size() == 0)
                    expected_rsps.push_back(make_rsp(STAT_EMPTY, '0, 1'b1));
                else
                    for (int i = 0; i < set_vals.size(); i++)
                        expected_rsps.push_back(make_rsp(STAT_LISTED, set_vals[i],
                                                         i == set_vals.size() - 1));
            end
            default: ;  // undefined mode: ignored, no results
        endcase
        if (set_vals.size() > peak_fill)
            peak_fill = set_vals.size();
    endtask

    task automatic check_result(input rsp_t got);
        rsp_t exp;
        results_seen++;
        if (got.status === STAT_FULL)
            full_replies++;
        if (got.status === STAT_DUPLICATE)
            dup_replies++;
        if (expected_rsps.size() == 0)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("%0t: unexpected result: status %0d value %0d last %0b",
                         $time, got.status, got.value_out, got.last);
            return;
        end
        exp = expected_rsps.pop_front();
        if (got.status !== exp.status || got.value_out !== exp.value_out
            || got.last !== exp.last)
        begin
            mismatches++;
            if (mismatches <= 10)
            begin
                $display("%0t: mismatch: expected status %0d value %0d last %0b",
                         $time, exp.status, exp.value_out, exp.last);
                $display("    got status %0d value %0d last %0b",
                         got.status, got.value_out, got.last);
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            set_vals.delete();
            expected_rsps.delete();
            mismatches   = 0;
            results_seen = 0;
            full_replies = 0;
            dup_replies  = 0;
            peak_fill    = 0;
            outstanding <= 0;
        end
        else
        begin
            // request first: a result taken at the same edge is always older
            if (req_valid && req_ready)
                predict_item(req);
            if (rsp_valid && rsp_ready)
                check_result(rsp);
            outstanding <= expected_rsps.size();
        end
    end

endmodule

@@ tb/sv/sorted_unique_set_table_test.sv @@
`timescale 1ns / 1ps
// Testbench top for the sorted unique set table: clock, reset, stimulus and
// verdict. Depends on sust_pkg, sust_set_checker and the block itself.
module sorted_unique_set_table_test
    import sust_pkg::*;
();

    localparam int    ITEMS      = 410;
    localparam int    CALM_ITEMS = 60;
    localparam int    HOLD_CYCLES = 300;
    localparam int    POOL_SIZE  = 24;
    localparam mode_t MODE_NONE  = mode_t'(2'd3);

    localparam int KIND_FILL  = 0;
    localparam int KIND_DRAIN = 1;
    localparam int KIND_MIXED = 2;

    localparam logic signed [VALUE_W-1:0] VAL_MIN = 32'sh8000_0000;
    localparam logic signed [VALUE_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;

    logic clk;
    logic rst_n;
    logic req_valid;
    logic req_ready;
    req_t req;
    logic rsp_valid;
    logic rsp_ready;
    rsp_t rsp;

    int mismatches;
    int outstanding;
    int results_seen;
    int full_replies;
    int dup_replies;
    int peak_fill;

    int items_sent;
    int rsp_stall_pct;
    bit hold_request;
    logic signed [VALUE_W-1:0] value_pool[POOL_SIZE];

    sorted_unique_set_table uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    sust_set_checker checker_i (
        .clk          (clk),
        .rst_n        (rst_n),
        .req_valid    (req_valid),
        .req_ready    (req_ready),
        .req          (req),
        .rsp_valid    (rsp_valid),
        .rsp_ready    (rsp_ready),
        .rsp          (rsp),
        .mismatches   (mismatches),
        .outstanding  (outstanding),
        .results_seen (results_seen),
        .full_replies (full_replies),
        .dup_replies  (dup_replies),
        .peak_fill    (peak_fill)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #3_000_000;
        $display("Timeout: %0d items sent, %0d results still expected",
                 items_sent, outstanding);
        $display("*** FAILED ***");
        $finish;
    end

    // result side: random stall bursts, plus one long hold-off on request
    initial
    begin
        rsp_ready = 1'b0;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            if (hold_request)
            begin
                hold_request = 1'b0;
                rsp_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else if ($urandom_range(0, 99) < rsp_stall_pct)
            begin
                rsp_ready <= 1'b0;
                repeat ($urandom_range(1, 5)) @(posedge clk);
            end
            else
            begin
                rsp_ready <= 1'b1;
                @(posedge clk);
            end
        end
    end

    // valid stays up between back-to-back items; idle() and the drain waits lower it
    task automatic send_item(input mode_t m, input logic signed [VALUE_W-1:0] v);
        req_t r;
        r.mode  = m;
        r.value = v;
        req       <= r;
        req_valid <= 1'b1;
        do @(posedge clk); while (!req_ready);
        items_sent++;
    endtask

    task automatic idle(input int pct);
        if ($urandom_range(0, 99) < pct)
        begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
    endtask

    task automatic refill_pool();
        for (int i = 0; i < POOL_SIZE; i++)
            case (i)
                0:       value_pool[i] = VAL_MIN;
                1:       value_pool[i] = VAL_MAX;
                2:       value_pool[i] = '0;
                3:       value_pool[i] = -1;
                default: value_pool[i] = ($urandom_range(0, 3) == 0)
                                         ? $signed($urandom_range(0, 40)) - 20
                                         : $signed($urandom());
            endcase
    endtask

    function automatic logic signed [VALUE_W-1:0] pick_value();
        if ($urandom_range(0, 99) < 85)
            return value_pool[$urandom_range(0, POOL_SIZE - 1)];
        return $signed($urandom());
    endfunction

    function automatic mode_t pick_mode(input int kind);
        int roll;
        int ins_pct;
        int rem_pct;
        roll = $urandom_range(0, 99);
        case (kind)
            KIND_FILL:
            begin
                ins_pct = 75;
                rem_pct = 10;
            end
            KIND_DRAIN:
            begin
                ins_pct = 15;
                rem_pct = 70;
            end
            default:
            begin
                ins_pct = 40;
                rem_pct = 40;
            end
        endcase
        if (roll < ins_pct)
            return MODE_INSERT;
        if (roll < ins_pct + rem_pct)
            return MODE_REMOVE;
        if (roll < 97)
            return MODE_DUMP;
        return MODE_NONE;
    endfunction

    initial
    begin
        logic signed [VALUE_W-1:0] fill_vals[18];
        logic signed [VALUE_W-1:0] v;
        int episode;
        int kind;
        int idle_pct;
        int n_items;

        rst_n         = 1'b0;
        req_valid     = 1'b0;
        req           = '0;
        items_sent    = 0;
        rsp_stall_pct = 20;
        hold_request  = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty table, extremes, every status but full, ignored mode
        send_item(MODE_DUMP, '0);
        send_item(MODE_REMOVE, 5);
        send_item(MODE_INSERT, '0);
        send_item(MODE_INSERT, VAL_MAX);
        send_item(MODE_INSERT, VAL_MIN);
        send_item(MODE_INSERT, -1);
        idle(100);
        send_item(MODE_INSERT, 1);
        send_item(MODE_INSERT, '0);
        send_item(MODE_REMOVE, 7);
        send_item(MODE_REMOVE, VAL_MAX);
        send_item(MODE_DUMP, '0);
        send_item(MODE_NONE, 32'shFFFF_FFFF);
        send_item(MODE_REMOVE, VAL_MIN);
        send_item(MODE_REMOVE, '0);
        send_item(MODE_REMOVE, -1);
        idle(100);
        send_item(MODE_REMOVE, 1);
        send_item(MODE_DUMP, '0);
        send_item(MODE_INSERT, 32'sh5555_5555);
        send_item(MODE_INSERT, 32'shAAAA_AAAA);
        send_item(MODE_DUMP, 32'shDEAD_BEEF);

        // fill past capacity, then a duplicate while full
        for (int i = 0; i < 18; i++)
        begin
            v = $signed($urandom());
            v[4:0] = i[4:0];
            fill_vals[i] = v;
            send_item(MODE_INSERT, v);
            idle(20);
        end
        send_item(MODE_INSERT, fill_vals[0]);
        send_item(MODE_DUMP, '0);

        episode = 0;
        while (items_sent < ITEMS)
        begin
            episode++;
            kind     = $urandom_range(KIND_FILL, KIND_MIXED);
            idle_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(10, 40);
            rsp_stall_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(10, 40);
            n_items  = $urandom_range(20, 40);
            refill_pool();
            if (items_sent >= ITEMS - CALM_ITEMS)
            begin
                idle_pct      = 0;
                rsp_stall_pct = 0;
            end
            if (episode == 3)
            begin
                // keep offering items while results back up
                kind         = KIND_FILL;
                idle_pct     = 0;
                hold_request = 1'b1;
            end
            if (episode == 5)
            begin
                req_valid <= 1'b0;
                @(posedge clk);
                wait (outstanding == 0);
                @(posedge clk);
            end
            for (int i = 0; i < n_items && items_sent < ITEMS; i++)
            begin
                if (items_sent >= ITEMS - CALM_ITEMS)
                begin
                    idle_pct      = 0;
                    rsp_stall_pct = 0;
                end
                send_item(pick_mode(kind), pick_value());
                idle(idle_pct);
            end
        end

        req_valid <= 1'b0;
        @(posedge clk);
        wait (outstanding == 0);
        repeat (40) @(posedge clk);

        $display("Run: %0d items sent, %0d results checked, table peaked at %0d entries",
                 items_sent, results_seen, peak_fill);
        $display("Run: %0d full-table replies, %0d duplicate replies, %0d mismatches",
                 full_replies, dup_replies, mismatches);
        if (mismatches == 0 && outstanding == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

@@ files.f @@
design/sust_pkg.sv
design/sorted_unique_set_table.sv
tb/sv/sust_set_checker.sv
tb/sv/sorted_unique_set_table_test.sv
